// ----- rtl/core/rpt_pkg.sv -----
package rpt_pkg;

    localparam int RESERVOIR_SIZE = 256;
    localparam int SLOT_W = $clog2(RESERVOIR_SIZE);
    localparam int MEM_AW = SLOT_W + 1;
    localparam int LEN_W  = $clog2(RESERVOIR_SIZE + 1);

    // len*p fits in LEN_W+7 bits; floor(x/100) = (x*DIV_R) >> DIV_SH, exact for x < 1.8M
    localparam int XW     = LEN_W + 7;
    localparam int DIV_SH = 26;
    localparam int DIV_R  = 671089;
    localparam int RW     = 20;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef logic [31:0] t_word;
    typedef logic [MEM_AW-1:0] t_addr;

endpackage

// ----- rtl/core/rpt_ram.sv -----
module rpt_ram (
    input  logic             i_clk,
    input  logic             i_we,
    input  rpt_pkg::t_addr   i_waddr,
    input  rpt_pkg::t_word   i_wdata,
    input  rpt_pkg::t_addr   i_raddr,
    output rpt_pkg::t_word   o_rdata
);

    rpt_pkg::t_word mem [2**rpt_pkg::MEM_AW];
    rpt_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/reservoir_percentile_tracker.sv -----
// Record: accepted every cycle unless a read is busy; the sample is registered, then
//   written to the reservoir RAM if its slot is in range. Read: stalls input through a
//   rank-by-counting sweep (len = min(count, size)) over the single RAM read port, longer
//   while an earlier result waits; the result then sits in an output register until taken.
// Reset (synchronous, active low) clears counts, maxima and control; the RAM
//   is not cleared, only slots written since the last read are ranked.
module reservoir_percentile_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic        i_epoch_select,
    input  logic [31:0] i_sample_value,
    input  logic [31:0] i_random_draw,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_total_count,
    output logic [31:0] o_max_value,
    output logic [31:0] o_median_value,
    output logic [31:0] o_p90_value,
    output logic [31:0] o_p99_value
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_CAND = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;
    localparam logic [2:0] S_EVAL = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam int LW = rpt_pkg::LEN_W;
    localparam int SW = rpt_pkg::SLOT_W;
    localparam logic [LW-1:0] SIZE_L = LW'(rpt_pkg::RESERVOIR_SIZE);
    localparam logic [32:0] SIZE_33 = 33'(rpt_pkg::RESERVOIR_SIZE);

    logic [2:0]  r_state;
    logic [31:0] r_count [2];
    logic [31:0] r_max   [2];

    // record pipeline
    logic          r_s1v, r_s1_bank, r_s1_small;
    logic [SW-1:0] r_s1_lo;
    logic [31:0]   r_s1_hi, r_s1_val;
    logic [63:0]   w_prod;
    logic [SW-1:0] w_slot;
    logic          w_we;

    // ranking
    logic                  r_bank;
    logic [31:0]           r_n, r_mx, r_cand, r_p50, r_p90, r_p99;
    logic [LW-1:0]         r_len, r_i, r_j, r_lt, r_eq, r_k50, r_k90, r_k99;
    logic [rpt_pkg::XW-1:0] r_x50, r_x90, r_x99;
    logic                  r_pv;
    logic [LW:0]           w_hi_end;
    rpt_pkg::t_addr        w_raddr;
    rpt_pkg::t_word        w_rdata;

    logic r_ov;
    logic [31:0] r_o_n, r_o_mx, r_o_50, r_o_90, r_o_99;

    logic w_acc;
    assign o_stall = (r_state != S_IDLE);
    assign w_acc   = i_valid && !o_stall;
    assign w_prod  = 64'(i_random_draw) * 64'(r_count[i_epoch_select]);

    assign w_slot = r_s1_small ? r_s1_lo : r_s1_hi[SW-1:0];
    assign w_we   = r_s1v && (r_s1_small || (33'(r_s1_hi) < SIZE_33));

    always_comb begin
        w_raddr = {r_bank, r_j[SW-1:0]};
        if (r_state == S_LOAD) begin
            w_raddr = {r_bank, r_i[SW-1:0]};
        end
    end

    rpt_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr ({r_s1_bank, w_slot}),
        .i_wdata (r_s1_val),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    function automatic logic [LW-1:0] div100(input logic [rpt_pkg::XW-1:0] x);
        logic [rpt_pkg::XW+rpt_pkg::RW-1:0] p;
        p = (rpt_pkg::XW+rpt_pkg::RW)'(x) * (rpt_pkg::XW+rpt_pkg::RW)'(rpt_pkg::DIV_R);
        return LW'(p >> rpt_pkg::DIV_SH);
    endfunction

    assign w_hi_end = {1'b0, r_lt} + {1'b0, r_eq};

    // payload registers
    always_ff @(posedge i_clk) begin
        r_s1_bank  <= i_epoch_select;
        r_s1_val   <= i_sample_value;
        r_s1_small <= r_count[i_epoch_select] < 32'(rpt_pkg::RESERVOIR_SIZE);
        r_s1_lo    <= r_count[i_epoch_select][SW-1:0];
        r_s1_hi    <= w_prod[63:32];
        r_x50 <= rpt_pkg::XW'(r_len) * rpt_pkg::XW'(50);
        r_x90 <= rpt_pkg::XW'(r_len) * rpt_pkg::XW'(90);
        r_x99 <= rpt_pkg::XW'(r_len) * rpt_pkg::XW'(99);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '{default: '0};
            r_max   <= '{default: '0};
            r_s1v   <= 1'b0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_s1v <= w_acc && (i_opcode == rpt_pkg::OP_RECORD);
            // a new result may replace the one taken at this edge
            if (r_state == S_OUT && (!r_ov || !i_stall)) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && i_opcode == rpt_pkg::OP_RECORD) begin
                        if (r_count[i_epoch_select] != 32'hFFFF_FFFF) begin
                            r_count[i_epoch_select] <= r_count[i_epoch_select] + 32'd1;
                        end
                        if (i_sample_value > r_max[i_epoch_select]) begin
                            r_max[i_epoch_select] <= i_sample_value;
                        end
                    end else if (w_acc) begin
                        r_bank <= i_epoch_select;
                        r_n    <= r_count[i_epoch_select];
                        r_mx   <= r_max[i_epoch_select];
                        r_len  <= (r_count[i_epoch_select] < 32'(rpt_pkg::RESERVOIR_SIZE))
                                  ? r_count[i_epoch_select][LW-1:0] : SIZE_L;
                        r_count[i_epoch_select] <= '0;
                        r_max[i_epoch_select]   <= '0;
                        r_p50 <= '0;
                        r_p90 <= '0;
                        r_p99 <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_DIV;
                S_DIV: begin
                    r_k50 <= div100(r_x50);
                    r_k90 <= div100(r_x90);
                    r_k99 <= div100(r_x99);
                    r_i   <= '0;
                    r_state <= (r_len == '0) ? S_OUT : S_LOAD;
                end
                S_LOAD: r_state <= S_CAND;
                S_CAND: begin
                    r_cand  <= w_rdata;
                    r_j     <= '0;
                    r_pv    <= 1'b0;
                    r_lt    <= '0;
                    r_eq    <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_j < r_len) begin
                        r_j  <= r_j + 1'b1;
                        r_pv <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        r_lt <= r_lt + LW'(w_rdata < r_cand);
                        r_eq <= r_eq + LW'(w_rdata == r_cand);
                    end
                    if (r_j == r_len && !r_pv) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    // candidate covers ranks lt .. lt+eq-1
                    if (r_lt <= r_k50 && {1'b0, r_k50} < w_hi_end) r_p50 <= r_cand;
                    if (r_lt <= r_k90 && {1'b0, r_k90} < w_hi_end) r_p90 <= r_cand;
                    if (r_lt <= r_k99 && {1'b0, r_k99} < w_hi_end) r_p99 <= r_cand;
                    r_i <= r_i + 1'b1;
                    r_state <= (r_i + 1'b1 == r_len) ? S_OUT : S_LOAD;
                end
                S_OUT: begin
                    if (!r_ov || !i_stall) begin
                        r_o_n   <= r_n;
                        r_o_mx  <= r_mx;
                        r_o_50  <= r_p50;
                        r_o_90  <= r_p90;
                        r_o_99  <= r_p99;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ov;
    assign o_total_count  = r_o_n;
    assign o_max_value    = r_o_mx;
    assign o_median_value = r_o_50;
    assign o_p90_value    = r_o_90;
    assign o_p99_value    = r_o_99;

endmodule

// ----- rtl/core/rpt_checker.sv -----
module rpt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_total_count,
    input logic [31:0] o_max_value,
    input logic [31:0] o_median_value,
    input logic [31:0] o_p90_value,
    input logic [31:0] o_p99_value
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_p99_value))
        else $error("stalled item dropped or changed");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("item valid after reset");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_median_value <= o_p90_value && o_p90_value <= o_p99_value
                    && o_p99_value <= o_max_value)
        else $error("percentiles out of order");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_total_count == 32'd0 |-> o_max_value == 32'd0
            && o_median_value == 32'd0 && o_p99_value == 32'd0)
        else $error("empty epoch reports nonzero");

endmodule

bind reservoir_percentile_tracker rpt_checker u_rpt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_total_count  (o_total_count),
    .o_max_value    (o_max_value),
    .o_median_value (o_median_value),
    .o_p90_value    (o_p90_value),
    .o_p99_value    (o_p99_value)
);

// ----- dv/reservoir_percentile_tracker_tb.sv -----
`timescale 1ns / 1ps

module reservoir_percentile_tracker_tb;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_CYCLES = 500;

    typedef struct {
        rpt_pkg::t_word total_count;
        rpt_pkg::t_word max_value;
        rpt_pkg::t_word median_value;
        rpt_pkg::t_word p90_value;
        rpt_pkg::t_word p99_value;
    } t_epoch_stats;

    // Tracks both epoch banks and queues the stats each read should return.
    class reservoir_scoreboard;
        rpt_pkg::t_word slots [2][rpt_pkg::RESERVOIR_SIZE];
        rpt_pkg::t_word counts [2];
        rpt_pkg::t_word maxima [2];
        t_epoch_stats pending_stats[$];
        int errors;
        int records;
        int reads;
        int checked;
        int big_reads;

        function new();
            for (int b = 0; b < 2; b++) begin
                counts[b] = '0;
                maxima[b] = '0;
                for (int s = 0; s < rpt_pkg::RESERVOIR_SIZE; s++) slots[b][s] = '0;
            end
            errors = 0;
            records = 0;
            reads = 0;
            checked = 0;
            big_reads = 0;
        endfunction

        function rpt_pkg::t_word rank_at(rpt_pkg::t_word sorted[rpt_pkg::RESERVOIR_SIZE],
                                         int len, int pct);
            return sorted[(len * pct) / 100];
        endfunction

        function void note_item(logic op, logic bank, rpt_pkg::t_word value,
                                rpt_pkg::t_word draw);
            logic [63:0] pick;
            rpt_pkg::t_word n;
            rpt_pkg::t_word sorted [rpt_pkg::RESERVOIR_SIZE];
            rpt_pkg::t_word key;
            t_epoch_stats st;
            int len;
            int j;
            n = counts[bank];
            if (op == rpt_pkg::OP_RECORD) begin
                records++;
                pick = 64'(n);
                if (n >= rpt_pkg::RESERVOIR_SIZE) pick = (64'(draw) * 64'(n)) >> 32;
                if (pick < rpt_pkg::RESERVOIR_SIZE) slots[bank][pick] = value;
                if (n != 32'hFFFF_FFFF) counts[bank] = n + 1;
                if (value > maxima[bank]) maxima[bank] = value;
            end else begin
                reads++;
                len = (n < rpt_pkg::RESERVOIR_SIZE) ? int'(n) : rpt_pkg::RESERVOIR_SIZE;
                if (len == rpt_pkg::RESERVOIR_SIZE) big_reads++;
                st.total_count = n;
                st.max_value = maxima[bank];
                st.median_value = '0;
                st.p90_value = '0;
                st.p99_value = '0;
                if (len > 0) begin
                    for (int i = 0; i < len; i++) sorted[i] = slots[bank][i];
                    for (int i = 1; i < len; i++) begin
                        key = sorted[i];
                        j = i;
                        while (j > 0 && sorted[j-1] > key) begin
                            sorted[j] = sorted[j-1];
                            j--;
                        end
                        sorted[j] = key;
                    end
                    st.median_value = rank_at(sorted, len, 50);
                    st.p90_value = rank_at(sorted, len, 90);
                    st.p99_value = rank_at(sorted, len, 99);
                end
                counts[bank] = '0;
                maxima[bank] = '0;
                pending_stats.push_back(st);
            end
        endfunction

        function void compare_field(string name, rpt_pkg::t_word exp_v,
                                    rpt_pkg::t_word act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_epoch_stats act);
            t_epoch_stats exp_s;
            if (pending_stats.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got count %h max %h",
                         $time, act.total_count, act.max_value);
                return;
            end
            exp_s = pending_stats.pop_front();
            checked++;
            compare_field("total_count", exp_s.total_count, act.total_count);
            compare_field("max_value", exp_s.max_value, act.max_value);
            compare_field("median_value", exp_s.median_value, act.median_value);
            compare_field("p90_value", exp_s.p90_value, act.p90_value);
            compare_field("p99_value", exp_s.p99_value, act.p99_value);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_opcode;
    logic        i_epoch_select;
    logic [31:0] i_sample_value;
    logic [31:0] i_random_draw;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_total_count;
    logic [31:0] o_max_value;
    logic [31:0] o_median_value;
    logic [31:0] o_p90_value;
    logic [31:0] o_p99_value;

    reservoir_scoreboard sb = new();

    logic hold_req;
    bit   hold_done;
    int   hold_left;
    int   wait_left;
    bit   stall_next;
    int   cycle_count;
    int   sent_items;
    bit   burst_mode;

    reservoir_percentile_tracker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_epoch_select (i_epoch_select),
        .i_sample_value (i_sample_value),
        .i_random_draw  (i_random_draw),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_total_count  (o_total_count),
        .o_max_value    (o_max_value),
        .o_median_value (o_median_value),
        .o_p90_value    (o_p90_value),
        .o_p99_value    (o_p99_value)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random stall per result, plus one long hold-off on request
    // that starts once a result is waiting.
    always @(posedge i_clk) begin
        t_epoch_stats act;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_left = 0;
            wait_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                act.total_count = o_total_count;
                act.max_value = o_max_value;
                act.median_value = o_median_value;
                act.p90_value = o_p90_value;
                act.p99_value = o_p99_value;
                sb.check_result(act);
                wait_left = ($urandom % 3 == 0) ? 0 : $urandom_range(0, 12);
            end
            if (hold_req && !hold_done && o_valid) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            stall_next = 1'b0;
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (wait_left > 0) begin
                wait_left--;
                stall_next = 1'b1;
            end
            i_stall <= stall_next;
        end
    end

    task automatic send_item(logic op, logic bank, rpt_pkg::t_word value,
                             rpt_pkg::t_word draw);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_epoch_select <= bank;
        i_sample_value <= value;
        i_random_draw <= draw;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(op, bank, value, draw);
        sent_items++;
    endtask

    task automatic record(logic bank, rpt_pkg::t_word value);
        send_item(rpt_pkg::OP_RECORD, bank, value, $urandom);
    endtask

    task automatic read_bank(logic bank);
        send_item(rpt_pkg::OP_READ, bank, $urandom, $urandom);
    endtask

    function automatic rpt_pkg::t_word pick_sample();
        case ($urandom % 6)
            0: return $urandom_range(0, 15);  // many ties
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int nrec;
        int episode;
        int big_left;
        logic main_bank;
        logic bank;
        bit big_run;

        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_opcode <= rpt_pkg::OP_RECORD;
        i_epoch_select <= 1'b0;
        i_sample_value <= '0;
        i_random_draw <= '0;
        hold_req <= 1'b0;
        sent_items = 0;
        burst_mode = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty banks, extremes, ties, single and pair samples
        read_bank(1'b0);
        read_bank(1'b1);
        send_item(rpt_pkg::OP_RECORD, 1'b0, 32'h0000_0000, 32'h0000_0000);
        send_item(rpt_pkg::OP_RECORD, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        record(1'b0, 32'h0000_0001);
        record(1'b0, 32'h8000_0000);
        record(1'b0, 32'h7FFF_FFFF);
        record(1'b1, 32'h5555_5555);
        record(1'b1, 32'hAAAA_AAAA);
        read_bank(1'b0);
        for (int i = 0; i < 3; i++) record(1'b1, 32'h0000_0005);
        read_bank(1'b1);
        read_bank(1'b1);
        record(1'b0, 32'h1234_5678);
        read_bank(1'b0);
        record(1'b1, 32'hFFFF_FFFE);
        record(1'b1, 32'h0000_0002);
        read_bank(1'b1);

        // long receiver hold-off: results pile up and the input stalls
        hold_req <= 1'b1;
        read_bank(1'b0);
        record(1'b1, 32'h0000_0009);
        read_bank(1'b0);
        record(1'b0, 32'h0000_0003);
        read_bank(1'b1);
        read_bank(1'b0);

        // random: record runs into a main bank, closed by a read; two runs
        // overflow the reservoir so replacement is exercised on both banks
        episode = 0;
        big_left = 2;
        while (sent_items < 650 || sb.reads < 45) begin
            main_bank = 1'($urandom % 2);
            burst_mode = ($urandom % 4 == 0);
            big_run = 1'b0;
            if (big_left > 0 && episode > 2 && ($urandom % 6 == 0 || sent_items > 300)) begin
                main_bank = big_left[0];
                nrec = $urandom_range(257, 300);
                big_left--;
                big_run = 1'b1;
            end else begin
                nrec = $urandom_range(1, 30);
            end
            for (int i = 0; i < nrec; i++) begin
                bank = (!big_run && $urandom % 4 == 0) ? !main_bank : main_bank;
                if (!big_run && $urandom % 40 == 0) read_bank(1'($urandom % 2));
                else record(bank, pick_sample());
            end
            read_bank(main_bank);
            if ($urandom % 3 == 0) read_bank(!main_bank);
            episode++;
        end
        burst_mode = 1'b0;
        i_valid <= 1'b0;

        while (sb.pending_stats.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d items: %0d records, %0d reads (%0d with a full reservoir).",
                 sent_items, sb.records, sb.reads, sb.big_reads);
        $display("Checked %0d results, %0d field errors.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending_stats.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
